// ----- rtl/tdfa_pkg.sv -----
// Package for the table-driven DFA longest-match unit.
// Holds the beat types, action and register codes, character constants
// and the word-character test used by the core.
package tdfa_pkg;

  // Table geometry and text limits.
  localparam int NUM_STATES_DEF = 256;
  localparam int MAX_TEXT_LEN   = 65536;
  localparam int POS_LIMIT_INT  = (MAX_TEXT_LEN - 1 > 65535) ? 65535 : MAX_TEXT_LEN - 1;
  localparam logic [15:0] POS_LIMIT = 16'(POS_LIMIT_INT);

  // Field widths.
  localparam int STATE_W = 8;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 16;
  localparam int ENTRY_W = STATE_W + 1;   // next state and accept bit

  // Special values.
  localparam logic [STATE_W-1:0] DEAD_STATE = 8'd0;
  localparam logic [BYTE_W-1:0]  NUL_BYTE   = 8'h00;

  // Character bounds for the word test.
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  // Input beat kinds.
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_TEXT  = 2'd2,
    ACT_NONE  = 2'd3
  } tdfa_action_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_NONWORD = 2'd0;
  localparam logic [1:0] CFG_START_WORD    = 2'd1;
  localparam logic [1:0] CFG_END_ANCHOR    = 2'd2;

  typedef struct packed {
    logic [STATE_W-1:0] start_nonword;
    logic [STATE_W-1:0] start_word;
    logic               end_anchor;
  } tdfa_cfg_t;

  // One input beat, unpacked.
  typedef struct packed {
    tdfa_action_t       action;
    logic [STATE_W-1:0] entry_state;
    logic [BYTE_W-1:0]  entry_byte;
    logic [STATE_W-1:0] entry_next;
    logic               entry_accept;
    logic [POS_W-1:0]   start_offset;
    logic               has_prev;
    logic [BYTE_W-1:0]  prev_byte;
    logic [BYTE_W-1:0]  text_byte;
  } tdfa_item_t;

  // One result beat.
  typedef struct packed {
    logic             matched;
    logic [POS_W-1:0] match_start;
    logic [POS_W-1:0] match_end;
  } tdfa_result_t;

  // True for letters, digits and underscore.
  function automatic logic is_word_byte(input logic [7:0] b);
    return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
           ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
           ((b >= CH_DIGIT_0) && (b <= CH_DIGIT_9)) ||
           (b == CH_UNDER);
  endfunction

endpackage

// ----- rtl/tdfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are not reset.
module tdfa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tdfa_core.sv -----
// Match core: table write and lookup addressing, run state and the
// result decision. Depends on tdfa_pkg; drives the transition table RAM.
module tdfa_core #(
  parameter int NUM_STATES = tdfa_pkg::NUM_STATES_DEF,
  parameter int AW         = $clog2(NUM_STATES) + 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tdfa_pkg::tdfa_cfg_t           cfg,
  input  logic                          in_accept,
  input  tdfa_pkg::tdfa_item_t          item,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [tdfa_pkg::ENTRY_W-1:0]  ram_wdata,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [tdfa_pkg::ENTRY_W-1:0]  ram_rdata,
  output logic                          push_valid,
  output tdfa_pkg::tdfa_result_t        push_data,
  output logic                          busy
);
  import tdfa_pkg::*;

  localparam int SW = AW - 8;
  localparam logic [STATE_W:0] STATE_LIM = (STATE_W+1)'(NUM_STATES);

  // Run state.
  logic [STATE_W-1:0] cur_state_r, cur_state_nxt;
  logic               running_r, running_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   begin_pos_r, begin_pos_nxt;
  logic               seen_r, seen_nxt;
  logic [POS_W-1:0]   acc_pos_r, acc_pos_nxt;
  logic               at_nul_r, at_nul_nxt;

  // Lookup stage: a text beat waiting for its table entry.
  logic               s_text_r, s_text_nxt;
  logic [BYTE_W-1:0]  s_byte_r, s_byte_nxt;
  logic               s_oob_r, s_oob_nxt;

  logic [STATE_W-1:0] tbl_next;
  logic               tbl_acc;
  logic               active;
  logic               stop;
  logic [STATE_W-1:0] src_state;
  logic               seen_upd;
  logic               at_nul_upd;
  logic [POS_W-1:0]   acc_pos_upd;
  logic               start_word;
  logic               matched;

  // Table entry for the beat in the lookup stage; states past the table read dead.
  always_comb begin
    tbl_next    = s_oob_r ? DEAD_STATE : ram_rdata[ENTRY_W-1:1];
    tbl_acc     = !s_oob_r && ram_rdata[0];
    active      = s_text_r && running_r;
    stop        = (s_byte_r == NUL_BYTE) || (tbl_next == DEAD_STATE);
    seen_upd    = seen_r || tbl_acc;
    at_nul_upd  = tbl_acc ? (s_byte_r == NUL_BYTE) : at_nul_r;
    acc_pos_upd = tbl_acc ? pos_r : acc_pos_r;
  end

  // The state for the next lookup comes straight from the table when a run continues.
  assign src_state = active ? tbl_next : cur_state_r;

  // Table write and lookup ports.
  always_comb begin
    ram_we    = in_accept && (item.action == ACT_LOAD) &&
                ({1'b0, item.entry_state} < STATE_LIM);
    ram_waddr = {item.entry_state[SW-1:0], item.entry_byte};
    ram_wdata = {item.entry_next, item.entry_accept};
    ram_re    = in_accept && (item.action == ACT_TEXT);
    ram_raddr = {src_state[SW-1:0], item.text_byte};
  end

  // Lookup stage loading.
  always_comb begin
    s_text_nxt = in_accept && (item.action == ACT_TEXT);
    s_byte_nxt = in_accept ? item.text_byte : s_byte_r;
    s_oob_nxt  = ({1'b0, src_state} >= STATE_LIM);
  end

  // Result of a run that stops on this beat.
  always_comb begin
    matched               = seen_upd && (!cfg.end_anchor || at_nul_upd);
    push_valid            = active && stop;
    push_data.matched     = matched;
    push_data.match_start = matched ? begin_pos_r : '0;
    push_data.match_end   = matched ? acc_pos_upd : '0;
  end

  assign start_word = item.has_prev && is_word_byte(item.prev_byte);

  // Run state update: the staged text beat first, then a newer begin beat overrides.
  always_comb begin
    cur_state_nxt = cur_state_r;
    running_nxt   = running_r;
    pos_nxt       = pos_r;
    begin_pos_nxt = begin_pos_r;
    seen_nxt      = seen_r;
    acc_pos_nxt   = acc_pos_r;
    at_nul_nxt    = at_nul_r;
    if (active) begin
      seen_nxt    = seen_upd;
      acc_pos_nxt = acc_pos_upd;
      at_nul_nxt  = at_nul_upd;
      if (stop) begin
        running_nxt = 1'b0;
      end else begin
        cur_state_nxt = tbl_next;
        if (pos_r < POS_LIMIT) begin
          pos_nxt = pos_r + 16'd1;
        end
      end
    end
    if (in_accept && (item.action == ACT_BEGIN)) begin
      cur_state_nxt = start_word ? cfg.start_word : cfg.start_nonword;
      running_nxt   = 1'b1;
      pos_nxt       = item.start_offset;
      begin_pos_nxt = item.start_offset;
      seen_nxt      = 1'b0;
      acc_pos_nxt   = '0;
      at_nul_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= '0;
      running_r   <= 1'b0;
      pos_r       <= '0;
      begin_pos_r <= '0;
      seen_r      <= 1'b0;
      acc_pos_r   <= '0;
      at_nul_r    <= 1'b0;
      s_text_r    <= 1'b0;
    end else begin
      cur_state_r <= cur_state_nxt;
      running_r   <= running_nxt;
      pos_r       <= pos_nxt;
      begin_pos_r <= begin_pos_nxt;
      seen_r      <= seen_nxt;
      acc_pos_r   <= acc_pos_nxt;
      at_nul_r    <= at_nul_nxt;
      s_text_r    <= s_text_nxt;
    end
  end

  // Stage payload needs no reset.
  always_ff @(posedge clk) begin
    s_byte_r <= s_byte_nxt;
    s_oob_r  <= s_oob_nxt;
  end

  assign busy = s_text_r;

endmodule

// ----- rtl/tdfa_outq.sv -----
// Result output register with one skid entry, so results can wait while
// new input beats are taken. Depends on tdfa_pkg.
module tdfa_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  input  tdfa_pkg::tdfa_result_t push_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tdfa_pkg::tdfa_result_t out_data,
  output logic [1:0]             held
);
  import tdfa_pkg::*;

  logic         head_valid_r, head_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  tdfa_result_t head_r, head_nxt;
  tdfa_result_t skid_r, skid_nxt;
  logic         pop;

  assign pop = head_valid_r && out_ready;

  // Move results forward from the skid entry and take in new ones.
  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        head_valid_nxt = 1'b0;
      end
    end
    if (push_valid) begin
      if (!head_valid_nxt) begin
        head_nxt       = push_data;
        head_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = head_valid_r;
  assign out_data  = head_r;
  assign held      = {1'b0, head_valid_r} + {1'b0, skid_valid_r};

endmodule

// ----- rtl/table_dfa_longest_match_unit.sv -----
// Table-driven DFA longest-match unit; depends on tdfa_pkg, tdfa_ram, tdfa_core, tdfa_outq.
// One input beat per cycle, set by the loop table RAM read -> next state -> read address.
// A stopping text beat's result passes the lookup stage, then the output head register, before out_tvalid.
// Input pauses while two results are held, or one is held with a text beat in lookup.
// rst_n is synchronous, active low: run state, output queue and configuration
// registers return to reset values; the transition table is not cleared.
module table_dfa_longest_match_unit #(
  parameter int NUM_STATES = tdfa_pkg::NUM_STATES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata, low bit up: entry_state[7:0], entry_byte[15:8], entry_next[23:16],
  // entry_accept[24], start_offset[40:25], has_prev[41], prev_byte[49:42],
  // text_byte[57:50], zero fill[63:58]
  input  logic [63:0] in_tdata,
  // tuser: action[1:0]
  input  logic [1:0]  in_tuser,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata, low bit up: match_start[15:0], match_end[31:16]
  output logic [31:0] out_tdata,
  // tuser: matched[0]
  output logic        out_tuser,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tdfa_pkg::*;

  localparam int AW = $clog2(NUM_STATES) + 8;

  tdfa_cfg_t         cfg_r, cfg_nxt;
  tdfa_item_t        item;
  tdfa_result_t      push_data;
  tdfa_result_t      out_data;
  logic              in_accept;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic              push_valid;
  logic              busy;
  logic [1:0]        held;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_NONWORD: cfg_nxt.start_nonword = cfg_data;
        CFG_START_WORD:    cfg_nxt.start_word    = cfg_data;
        CFG_END_ANCHOR:    cfg_nxt.end_anchor    = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_nonword <= 8'd1;
      cfg_r.start_word    <= 8'd1;
      cfg_r.end_anchor    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Unpack the input beat.
  always_comb begin
    item.action       = tdfa_action_t'(in_tuser);
    item.entry_state  = in_tdata[7:0];
    item.entry_byte   = in_tdata[15:8];
    item.entry_next   = in_tdata[23:16];
    item.entry_accept = in_tdata[24];
    item.start_offset = in_tdata[40:25];
    item.has_prev     = in_tdata[41];
    item.prev_byte    = in_tdata[49:42];
    item.text_byte    = in_tdata[57:50];
  end

  // Take a beat while its possible result and those queued still fit.
  assign in_tready = (held == 2'd0) || ((held == 2'd1) && !busy);
  assign in_accept = in_tvalid && in_tready;

  tdfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_STATES * 256)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tdfa_core #(
    .NUM_STATES (NUM_STATES),
    .AW         (AW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_accept  (in_accept),
    .item       (item),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .push_valid (push_valid),
    .push_data  (push_data),
    .busy       (busy)
  );

  tdfa_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_data),
    .held       (held)
  );

  // Pack the result beat.
  assign out_tdata = {out_data.match_end, out_data.match_start};
  assign out_tuser = out_data.matched;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for table_dfa_longest_match_unit.
// Needs only tdfa_pkg and the unit; a class predicts each match result and
// checks the result stream, while plain tasks drive the input and config ports.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tdfa_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 120;

  // Bytes on both sides of the word-character ranges.
  localparam logic [7:0] BOUNDARY_BYTES [16] = '{
    8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41, 8'h5A, 8'h5B,
    8'h5E, 8'h5F, 8'h60, 8'h61, 8'h7A, 8'h7B, 8'h00, 8'hFF
  };

  // Shadow of the unit: transition table, run state and expected match results.
  class dfa_match_tracker;
    logic [7:0]   next_tab [65536];
    bit           acc_tab [65536];
    bit           loaded [65536];
    logic [7:0]   start_nonword = 8'd1;
    logic [7:0]   start_word = 8'd1;
    bit           end_anchor = 1'b0;
    logic [7:0]   cur_state = DEAD_STATE;
    bit           running = 1'b0;
    logic [15:0]  pos = '0;
    logic [15:0]  begin_pos = '0;
    logic [15:0]  accept_pos = '0;
    bit           accept_seen = 1'b0;
    bit           accept_nul = 1'b0;
    tdfa_result_t pending_matches [$];
    int           errors = 0;

    function void set_reg(input logic [1:0] idx, input logic [7:0] val);
      case (idx)
        CFG_START_NONWORD: start_nonword = val;
        CFG_START_WORD:    start_word = val;
        CFG_END_ANCHOR:    end_anchor = val[0];
        default: ;
      endcase
    endfunction

    function bit word_char(input logic [7:0] b);
      return (b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
             (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) || b == CH_UNDER;
    endfunction

    // Picks one byte that already has an entry for the given state.
    function bit pick_byte(input logic [7:0] st, output logic [7:0] b);
      int cnt;
      int k;
      cnt = 0;
      b = NUL_BYTE;
      for (int i = 0; i < 256; i++) if (loaded[{st, 8'(i)}]) cnt++;
      if (cnt == 0) return 1'b0;
      k = $urandom_range(cnt - 1);
      for (int i = 0; i < 256; i++) begin
        if (loaded[{st, 8'(i)}]) begin
          if (k == 0) begin
            b = 8'(i);
            return 1'b1;
          end
          k--;
        end
      end
      return 1'b0;
    endfunction

    // Advances the shadow by one accepted input beat.
    function void take_item(input tdfa_item_t it);
      logic [15:0]  idx;
      logic [7:0]   nx;
      tdfa_result_t r;
      case (it.action)
        ACT_LOAD: begin
          idx = {it.entry_state, it.entry_byte};
          next_tab[idx] = it.entry_next;
          acc_tab[idx] = it.entry_accept;
          loaded[idx] = 1'b1;
        end
        ACT_BEGIN: begin
          cur_state = (it.has_prev && word_char(it.prev_byte)) ? start_word : start_nonword;
          begin_pos = it.start_offset;
          pos = it.start_offset;
          running = 1'b1;
          accept_seen = 1'b0;
          accept_pos = '0;
          accept_nul = 1'b0;
        end
        ACT_TEXT: begin
          if (running) begin
            idx = {cur_state, it.text_byte};
            nx = next_tab[idx];
            if (acc_tab[idx]) begin
              accept_seen = 1'b1;
              accept_pos = pos;
              accept_nul = (it.text_byte == NUL_BYTE);
            end
            if (it.text_byte != NUL_BYTE && nx != DEAD_STATE) begin
              cur_state = nx;
              if (pos < POS_LIMIT) pos++;
            end else begin
              running = 1'b0;
              r.matched = accept_seen && (!end_anchor || accept_nul);
              r.match_start = r.matched ? begin_pos : '0;
              r.match_end = r.matched ? accept_pos : '0;
              pending_matches.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compares one result beat with the oldest expected match.
    function void check_match(input tdfa_result_t got);
      tdfa_result_t want;
      if (pending_matches.size() == 0) begin
        $error("unexpected result: matched=%0d start=%0d end=%0d",
               got.matched, got.match_start, got.match_end);
        errors++;
        return;
      end
      want = pending_matches.pop_front();
      if (got.matched !== want.matched) begin
        $error("matched: expected %0d, got %0d", want.matched, got.matched);
        errors++;
      end
      if (got.match_start !== want.match_start) begin
        $error("match_start: expected %0d, got %0d", want.match_start, got.match_start);
        errors++;
      end
      if (got.match_end !== want.match_end) begin
        $error("match_end: expected %0d, got %0d", want.match_end, got.match_end);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = ACT_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  dfa_match_tracker tracker = new();
  int idle_pct = 14;
  bit start_hold = 1'b0;
  bit hold_taken = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int items_done = 0;
  int results_seen = 0;
  int settings_used = 0;

  table_dfa_longest_match_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_match('{matched: out_tuser, match_start: out_tdata[15:0],
                            match_end: out_tdata[31:16]});
      results_seen++;
    end
    if (start_hold && !hold_taken) begin
      hold_taken = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Beat builders; fields the action does not use carry random bits.
  function automatic tdfa_item_t mk_any(input tdfa_action_t a);
    logic [63:0] r;
    tdfa_item_t  it;
    r = {$urandom, $urandom};
    it = r[$bits(tdfa_item_t)-1:0];
    it.action = a;
    return it;
  endfunction

  function automatic tdfa_item_t mk_load(input logic [7:0] st, input logic [7:0] b,
                                         input logic [7:0] nx, input bit acc);
    tdfa_item_t it;
    it = mk_any(ACT_LOAD);
    it.entry_state = st;
    it.entry_byte = b;
    it.entry_next = nx;
    it.entry_accept = acc;
    return it;
  endfunction

  function automatic tdfa_item_t mk_begin(input logic [15:0] off, input bit hp,
                                          input logic [7:0] pb);
    tdfa_item_t it;
    it = mk_any(ACT_BEGIN);
    it.start_offset = off;
    it.has_prev = hp;
    it.prev_byte = pb;
    return it;
  endfunction

  function automatic tdfa_item_t mk_text(input logic [7:0] b);
    tdfa_item_t it;
    it = mk_any(ACT_TEXT);
    it.text_byte = b;
    return it;
  endfunction

  // Next state for a new entry: mostly the small loop of states, sometimes dead.
  function automatic logic [7:0] pick_next();
    int r;
    r = $urandom_range(99);
    if (r < 15) return DEAD_STATE;
    if (r < 20) return 8'($urandom_range(255));
    return 8'($urandom_range(6, 1));
  endfunction

  function automatic logic [7:0] pick_entry_byte();
    case ($urandom_range(6))
      0: return NUL_BYTE;
      1: return 8'hFF;
      2: return CH_LOWER_A;
      3: return CH_UNDER;
      4: return CH_DIGIT_0;
      5: return CH_UPPER_Z;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_offset();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'hFFF0 + 16'($urandom_range(15));
    if (r < 12) return 16'h0000;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [7:0] pick_prev();
    if ($urandom_range(1)) return BOUNDARY_BYTES[$urandom_range(15)];
    return 8'($urandom_range(255));
  endfunction

  // Offers one input beat, with random gaps, and waits for it to be taken.
  task automatic send_item(input tdfa_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.action;
    in_tdata <= {6'd0, it.text_byte, it.prev_byte, it.has_prev, it.start_offset,
                 it.entry_accept, it.entry_next, it.entry_byte, it.entry_state};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (it.action != ACT_NONE && !(it.action == ACT_TEXT && !tracker.running)) items_done++;
    tracker.take_item(it);
  endtask

  // Writes all three registers back to back on the config channel.
  task automatic write_setting(input logic [7:0] nw, input logic [7:0] w, input bit anc);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx = '{CFG_START_NONWORD, CFG_START_WORD, CFG_END_ANCHOR};
    val = '{nw, w, {7'd0, anc}};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.set_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Stops offering beats and lets every expected match come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending_matches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One text beat whose table entry is known; loads the entry first if needed.
  task automatic text_step(input bit to_nul);
    logic [7:0] st;
    logic [7:0] b;
    st = tracker.cur_state;
    b = NUL_BYTE;
    if (!to_nul && ($urandom_range(99) < 25 || !tracker.pick_byte(st, b)))
      b = 8'($urandom_range(255));
    if (!tracker.loaded[{st, b}])
      send_item(mk_load(st, b, pick_next(), 1'($urandom_range(1))));
    send_item(mk_text(b));
  endtask

  // A begin beat followed by a walk through the table, with some noise mixed in.
  task automatic do_run(input int max_len, input int close_pct);
    int len;
    int r;
    send_item(mk_begin(pick_offset(), 1'($urandom_range(1)), pick_prev()));
    len = $urandom_range(max_len);
    for (int i = 0; i < len && tracker.running; i++) begin
      r = $urandom_range(99);
      if (r < 4) send_item(mk_any(ACT_NONE));
      else if (r < 8) send_item(mk_any(ACT_LOAD));
      else if (r < 10) send_item(mk_begin(pick_offset(), 1'($urandom_range(1)), pick_prev()));
      else text_step(1'b0);
    end
    if (tracker.running && $urandom_range(99) < close_pct) text_step(1'b1);
  endtask

  // One configuration setting: a fresh small automaton, then random runs.
  task automatic run_phase(input logic [7:0] nw, input logic [7:0] w, input bit anc,
                           input int pct, input bit squeeze);
    int         phase_end;
    logic [7:0] st;
    logic [7:0] b;
    drain();
    write_setting(nw, w, anc);
    idle_pct <= pct;
    for (int k = 0; k < 8; k++) begin
      st = (k == 0) ? nw : (k == 1) ? w : 8'(k - 1);
      repeat (4) send_item(mk_load(st, pick_entry_byte(), pick_next(), 1'($urandom_range(1))));
    end
    // Many short runs while the result side is held off, so the unit backs up.
    if (squeeze) begin
      start_hold <= 1'b1;
      repeat (40) do_run(0, 100);
    end
    phase_end = items_done + PHASE_ITEMS;
    while (items_done < phase_end) begin
      // A text beat while no run is active is ignored.
      if (!tracker.running && $urandom_range(99) < 10 && tracker.pick_byte(tracker.cur_state, b))
        send_item(mk_text(b));
      do_run(($urandom_range(9) == 0) ? 40 : 12, 75);
    end
    if (tracker.running) text_step(1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_setting(8'd1, 8'd2, 1'b0);

    // Directed: a small table, then runs that hit each special case.
    send_item(mk_load(8'd1, CH_LOWER_A, 8'd1, 1'b0));
    send_item(mk_load(8'd1, 8'h62, 8'd3, 1'b1));
    send_item(mk_load(8'd3, NUL_BYTE, DEAD_STATE, 1'b1));
    send_item(mk_load(8'd3, 8'hFF, DEAD_STATE, 1'b0));
    send_item(mk_load(8'd2, CH_LOWER_A, 8'd1, 1'b1));
    send_item(mk_load(8'd1, NUL_BYTE, 8'd7, 1'b0));
    send_item('1);
    // Non-word start, accept on the terminating NUL.
    send_item(mk_begin(16'h0000, 1'b0, CH_LOWER_A));
    send_item(mk_text(CH_LOWER_A));
    send_item(mk_text(CH_LOWER_A));
    send_item(mk_text(8'h62));
    send_item(mk_text(NUL_BYTE));
    // Text while idle is dropped.
    send_item(mk_text(8'hFF));
    // Word start near the top of the position range, ends on the dead state.
    send_item(mk_begin(16'hFFFE, 1'b1, CH_UNDER));
    send_item(mk_text(CH_LOWER_A));
    send_item(mk_text(CH_LOWER_A));
    send_item(mk_text(8'h62));
    send_item(mk_text(8'hFF));
    // A begin while a run is active drops that run.
    send_item(mk_begin(16'h1234, 1'b1, 8'h7B));
    send_item(mk_text(8'h62));
    send_item(mk_begin(16'h0005, 1'b1, CH_UPPER_Z));
    send_item(mk_text(CH_LOWER_A));
    send_item(mk_text(NUL_BYTE));
    // No accept at all.
    send_item(mk_begin(16'hFFFF, 1'b0, CH_DIGIT_9));
    send_item(mk_text(NUL_BYTE));

    // Random phases across register settings, extremes included.
    run_phase(8'd0, 8'd255, 1'b1, 14, 1'b0);
    run_phase(8'd255, 8'd0, 1'b0, 0, 1'b0);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1, 14, 1'b1);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, 14, 1'b0);
    run_phase(8'd1, 8'd1, 1'b1, 14, 1'b0);
    drain();

    $display("Covered %0d input beats and %0d match results over %0d register settings,",
             items_done, results_seen, settings_used);
    $display("with input gaps, output stalls and one long output hold-off.");
    if (tracker.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tdfa_pkg.sv
rtl/tdfa_ram.sv
rtl/tdfa_core.sv
rtl/tdfa_outq.sv
rtl/table_dfa_longest_match_unit.sv
test/testbench.sv
